// ===== hw/rtl/mefm_pkg.sv =====
// package for the multichannel edge frequency meter
// holds the item structs, the sequencer state type and fixed constants; no dependencies
`default_nettype none

package mefm_pkg;

	localparam int unsigned CH_W      = 5;
	localparam int unsigned TS_W      = 32;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned FREQ_W    = 20;
	localparam int unsigned DIV_W     = 32;
	localparam int unsigned WORD_W    = CNT_W + TS_W;

	localparam logic [DIV_W-1:0] MICROS_PER_SECOND = 32'd1000000;
	localparam logic [CNT_W-1:0] PULSES_RESET      = 16'd10;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [TS_W-1:0] timestamp_us;
	} sample_t;

	typedef struct packed {
		logic [CH_W-1:0]   result_channel;
		logic [FREQ_W-1:0] frequency_hz;
		logic              period_zero_error;
	} meas_t;

	// per-channel memory word
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [TS_W-1:0]  start;
	} chan_word_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_DIV1,
		ST_DIV2,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multichannel_edge_frequency_meter_unit.sv =====
// multichannel edge frequency meter top level; uses mefm_pkg, mefm_ram and mefm_div
// a result passes through ram read, evaluate, two divider runs (one on a zero period,
//   none at pulse count zero) and the output register
// a new item is accepted only once the previous one is through and the sequencer is idle;
//   a result still waiting on meas_ready delays the next acceptance
// reset: pulse count 10, per-channel valid bits clear so counters read zero; start times unknown
`default_nettype none

module multichannel_edge_frequency_meter_unit #(
	parameter int unsigned CHANNELS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 sample_valid,
	output logic                sample_ready,
	input  wire mefm_pkg::sample_t sample,
	output logic                meas_valid,
	input  wire                 meas_ready,
	output mefm_pkg::meas_t     meas,
	input  wire                 cfg_we,
	input  wire [mefm_pkg::CNT_W-1:0] cfg_wdata
);

	localparam int unsigned AW   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int unsigned CMPW = 9;

	mefm_pkg::state_t           state_q, state_nx;
	logic [mefm_pkg::CNT_W-1:0] pulses_q;
	logic [mefm_pkg::CH_W-1:0]  ch_q;
	logic [mefm_pkg::TS_W-1:0]  ts_q;
	logic [CHANNELS-1:0]        vld_q;
	logic [mefm_pkg::FREQ_W-1:0] freq_q;
	logic                       err_q;
	mefm_pkg::meas_t            meas_q;
	logic                       meas_valid_q;

	logic                       in_range;
	logic                       accept;
	logic                       out_free;
	logic                       ram_re;
	logic                       ram_we;
	mefm_pkg::chan_word_t       ram_wdata;
	logic [mefm_pkg::WORD_W-1:0] ram_rdata;
	mefm_pkg::chan_word_t       rd_word;
	logic [mefm_pkg::CNT_W-1:0] cnt_rd;
	logic [mefm_pkg::TS_W-1:0]  elapsed;
	mefm_pkg::div_req_t         div_req;
	mefm_pkg::div_stat_t        div_stat;
	logic                       load_res;
	logic [mefm_pkg::FREQ_W-1:0] res_freq;
	logic                       res_err;

	assign in_range = {{(CMPW - mefm_pkg::CH_W){1'b0}}, sample.channel} < CMPW'(CHANNELS);
	assign accept   = sample_valid && sample_ready;
	assign out_free = !meas_valid_q || meas_ready;

	assign rd_word = mefm_pkg::chan_word_t'(ram_rdata);
	assign cnt_rd  = vld_q[AW'(ch_q)] ? rd_word.cnt : '0;
	assign elapsed = ts_q - rd_word.start;

	mefm_ram #(
		.WIDTH (mefm_pkg::WORD_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(ch_q)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(ch_q)),
		.rdata (ram_rdata)
	);

	mefm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	always_comb begin
		state_nx      = state_q;
		sample_ready  = 1'b0;
		ram_re        = 1'b0;
		ram_we        = 1'b0;
		ram_wdata     = rd_word;
		div_req       = '0;
		load_res      = 1'b0;
		res_freq      = '0;
		res_err       = 1'b0;
		unique case (state_q)
			mefm_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid && in_range) begin
					state_nx = mefm_pkg::ST_RD;
				end
			end
			mefm_pkg::ST_RD: begin
				ram_re   = 1'b1;
				state_nx = mefm_pkg::ST_EVAL;
			end
			mefm_pkg::ST_EVAL: begin
				if (pulses_q == '0) begin
					ram_we          = 1'b1;
					ram_wdata.cnt   = '0;
					ram_wdata.start = ts_q;
					load_res        = 1'b1;
					res_err         = 1'b1;
					state_nx        = mefm_pkg::ST_FIN;
				end else if (cnt_rd == '0) begin
					ram_we          = 1'b1;
					ram_wdata.cnt   = mefm_pkg::CNT_W'(1);
					ram_wdata.start = ts_q;
					state_nx        = mefm_pkg::ST_IDLE;
				end else if (cnt_rd < pulses_q) begin
					ram_we        = 1'b1;
					ram_wdata.cnt = cnt_rd + 1'b1;
					state_nx      = mefm_pkg::ST_IDLE;
				end else begin
					// window closes: clear the counter now, divide afterwards
					ram_we           = 1'b1;
					ram_wdata.cnt    = '0;
					div_req.start    = 1'b1;
					div_req.dividend = elapsed;
					div_req.divisor  = {{(mefm_pkg::DIV_W - mefm_pkg::CNT_W){1'b0}}, pulses_q};
					state_nx         = mefm_pkg::ST_DIV1;
				end
			end
			mefm_pkg::ST_DIV1: begin
				if (div_stat.done) begin
					if (div_stat.quotient == '0) begin
						load_res = 1'b1;
						res_err  = 1'b1;
						state_nx = mefm_pkg::ST_FIN;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = mefm_pkg::MICROS_PER_SECOND;
						div_req.divisor  = div_stat.quotient;
						state_nx         = mefm_pkg::ST_DIV2;
					end
				end
			end
			mefm_pkg::ST_DIV2: begin
				if (div_stat.done) begin
					load_res = 1'b1;
					res_freq = div_stat.quotient[mefm_pkg::FREQ_W-1:0];
					state_nx = mefm_pkg::ST_FIN;
				end
			end
			mefm_pkg::ST_FIN: begin
				if (out_free) begin
					state_nx = mefm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = mefm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mefm_pkg::ST_IDLE;
			pulses_q     <= mefm_pkg::PULSES_RESET;
			vld_q        <= '0;
			meas_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				pulses_q <= cfg_wdata;
			end
			if (ram_we) begin
				vld_q[AW'(ch_q)] <= 1'b1;
			end
			if (state_q == mefm_pkg::ST_FIN && out_free) begin
				meas_valid_q <= 1'b1;
			end else if (meas_ready) begin
				meas_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= sample.channel;
			ts_q <= sample.timestamp_us;
		end
		if (load_res) begin
			freq_q <= res_freq;
			err_q  <= res_err;
		end
		if (state_q == mefm_pkg::ST_FIN && out_free) begin
			meas_q.result_channel    <= ch_q;
			meas_q.frequency_hz      <= freq_q;
			meas_q.period_zero_error <= err_q;
		end
	end

	assign meas_valid = meas_valid_q;
	assign meas       = meas_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == mefm_pkg::ST_DIV1 || state_q == mefm_pkg::ST_DIV2))
		else $error("divider finished outside a divide state");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_ram_write_eval: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == mefm_pkg::ST_EVAL && $past(state_q) == mefm_pkg::ST_RD)
		else $error("channel write without a preceding read");

	a_in_range_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_range |=> state_q == mefm_pkg::ST_RD)
		else $error("accepted item did not start a channel read");

	a_err_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas.period_zero_error |-> meas.frequency_hz == '0)
		else $error("error result carries a frequency");

endmodule

`default_nettype wire

// ===== hw/rtl/mefm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mefm_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 32
) (
	input  wire                                           clk,
	input  wire                                           we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]     waddr,
	input  wire [WIDTH-1:0]                               wdata,
	input  wire                                           re,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]     raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mefm_div.sv =====
// shared restoring divider, two quotient bits per cycle
// depends on mefm_pkg
`default_nettype none

module mefm_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire mefm_pkg::div_req_t req,
	output mefm_pkg::div_stat_t stat
);

	localparam int unsigned DW     = mefm_pkg::DIV_W;
	localparam int unsigned STEPS  = 2;
	localparam int unsigned CYCLES = DW / STEPS;
	localparam int unsigned CW     = $clog2(CYCLES);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cyc_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW-1:0] rem_nx;
	logic [DW-1:0] quo_nx;

	always_comb begin
		logic [DW:0]   t;
		logic [DW-1:0] r;
		logic [DW-1:0] q;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, q[DW-1]};
			q = {q[DW-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t    = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[DW-1:0];
		end
		rem_nx = r;
		quo_nx = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cyc_q  <= '0;
			end else if (busy_q) begin
				cyc_q <= cyc_q + 1'b1;
				if (cyc_q == CW'(CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule

`default_nettype wire
